### rtl/lj_pkg.sv
// Shared widths, reset values and register indexes for the Lennard-Jones pair energy block.
`default_nettype none
package lj_pkg;
    localparam int NUM_TYPES_DEF = 16;
    localparam int TYPE_W        = 4;
    localparam int COORD_W       = 16;
    localparam int RADIUS_W      = 12;
    localparam int DEPTH_W       = 16;
    localparam int ENERGY_W      = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int COEFF_W       = 16;
    localparam int CUTOFF_W      = 15;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_VDW_COEFF   = 2'd0;
    localparam t_cfg_idx CFG_CUT_MODE    = 2'd1;
    localparam t_cfg_idx CFG_CUTOFF_DIST = 2'd2;

    localparam logic [COEFF_W-1:0]  VDW_COEFF_RST   = 16'd2723;
    localparam logic                CUT_MODE_RST    = 1'b0;
    localparam logic [CUTOFF_W-1:0] CUTOFF_DIST_RST = 15'd2048;
endpackage
`default_nettype wire

### rtl/lennard_jones_pair_energy_sum.sv
// Lennard-Jones 12-6 pair energy accumulator on one shared 32x32 multiplier.
`default_nettype none
//  channel   direction  handshake                     word
//  in        input      i_in_valid / o_in_stall       kind, types, coords, radius, depth, last
//  out       output     o_out_valid / i_out_stall     total_energy, saturated
//  cfg       input      i_cfg_valid / o_cfg_ready     index, data (always ready)
//
//  A load word is written to the type table on accept and leaves the block idle. A pair
//  word holds the input stall from accept until it is summed: table reads, squares and
//  products on the shared multiplier, a 16-step square root, the coefficient product,
//  a 56-step bit-serial divider, six 48x48 scaled products on the multiplier, then the
//  term and the sum. Pairs that add zero skip the arithmetic.
//  Reset (synchronous, active low) clears the table valid bits, the sum and the flag.
//  The output word sits in a register; a stalled output only holds the block when the
//  next last pair finishes before it is taken.
module lennard_jones_pair_energy_sum #(
    parameter int NUM_TYPES = lj_pkg::NUM_TYPES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_kind,
    input  wire logic [lj_pkg::TYPE_W-1:0]        i_type_a,
    input  wire logic [lj_pkg::TYPE_W-1:0]        i_type_b,
    input  wire logic signed [lj_pkg::COORD_W-1:0] i_ax,
    input  wire logic signed [lj_pkg::COORD_W-1:0] i_ay,
    input  wire logic signed [lj_pkg::COORD_W-1:0] i_az,
    input  wire logic signed [lj_pkg::COORD_W-1:0] i_bx,
    input  wire logic signed [lj_pkg::COORD_W-1:0] i_by,
    input  wire logic signed [lj_pkg::COORD_W-1:0] i_bz,
    input  wire logic [lj_pkg::RADIUS_W-1:0]      i_radius,
    input  wire logic [lj_pkg::DEPTH_W-1:0]       i_well_depth,
    input  wire logic                             i_last,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [lj_pkg::ENERGY_W-1:0]    o_total_energy,
    output logic                                  o_saturated,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [lj_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lj_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lj_pkg::*;

    localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int WIDE_W = IDX_W + TYPE_W;
    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS = 56;
    localparam int MUL_COUNT = 6;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RDA  = 5'd1;
    localparam logic [4:0] S_RDB  = 5'd2;
    localparam logic [4:0] S_RDW  = 5'd3;
    localparam logic [4:0] S_SQX  = 5'd4;
    localparam logic [4:0] S_SQY  = 5'd5;
    localparam logic [4:0] S_SQZ  = 5'd6;
    localparam logic [4:0] S_CUT  = 5'd7;
    localparam logic [4:0] S_SS   = 5'd8;
    localparam logic [4:0] S_DD   = 5'd9;
    localparam logic [4:0] S_CHK  = 5'd10;
    localparam logic [4:0] S_SQRT = 5'd11;
    localparam logic [4:0] S_EPS  = 5'd12;
    localparam logic [4:0] S_EPW  = 5'd13;
    localparam logic [4:0] S_DIV  = 5'd14;
    localparam logic [4:0] S_MUL  = 5'd15;
    localparam logic [4:0] S_TERM = 5'd16;
    localparam logic [4:0] S_ACC  = 5'd17;

    localparam logic [47:0] CAP = 48'h8000_0000_0000;

    // configuration
    logic [COEFF_W-1:0]  r_vdw_coeff;
    logic                r_cut_mode;
    logic [CUTOFF_W-1:0] r_cutoff;

    // type table
    logic [RADIUS_W-1:0] r_rad_mem [NUM_TYPES];
    logic [DEPTH_W-1:0]  r_dep_mem [NUM_TYPES];
    logic [NUM_TYPES-1:0] r_tab_vld;
    logic [RADIUS_W-1:0] r_rd_rad;
    logic [DEPTH_W-1:0]  r_rd_dep;
    logic                r_rd_vld;

    // sequencer and working registers
    logic [4:0]          r_state;
    logic [TYPE_W-1:0]   r_ta, r_tb;
    logic                r_ok, r_last;
    logic [15:0]         r_dx, r_dy, r_dz;
    logic [RADIUS_W-1:0] r_ra, r_rb;
    logic [DEPTH_W-1:0]  r_da, r_db;
    logic [33:0]         r_d2;
    logic [29:0]         r_cut2;
    logic [25:0]         r_s2;
    logic [63:0]         r_prod;
    logic [31:0]         r_sq_v;
    logic [17:0]         r_sq_rem;
    logic [15:0]         r_sq_res;
    logic [5:0]          r_cnt;
    logic [55:0]         r_num;
    logic [55:0]         r_q;
    logic [29:0]         r_rem;
    logic [47:0]         r_t, r_t6;
    logic [63:0]         r_acc;
    logic [2:0]          r_sub;
    logic [2:0]          r_midx;
    logic                r_pclip;
    logic signed [ENERGY_W-1:0] r_term;
    logic signed [ENERGY_W-1:0] r_sum;
    logic                r_clip_flag;
    logic                r_out_valid;
    logic signed [ENERGY_W-1:0] r_out_energy;
    logic                r_out_sat;

    logic                in_acc;
    logic [WIDE_W-1:0]   wa, wb, wrange;
    logic [IDX_W-1:0]    addr_in, addr_a, addr_b;
    logic signed [16:0]  dx17, dy17, dz17;
    logic [31:0]         mul_a, mul_b;
    logic [12:0]         s_sum;
    logic [47:0]         q48;
    logic [19:0]         sq_sh, sq_trial;
    logic [30:0]         div_sh;
    logic [63:0]         mul_res;
    logic [47:0]         mul_cap;
    logic                mul_ovf;
    logic [49:0]         diff;
    logic signed [32:0]  sum33;
    logic                sum_ovf;
    logic signed [ENERGY_W-1:0] sum_sat;
    logic                zero_pair;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_total_energy = r_out_energy;
    assign o_saturated = r_out_sat;

    // widen type fields against the table depth
    assign wrange  = WIDE_W'(NUM_TYPES);
    assign wa      = {{IDX_W{1'b0}}, i_type_a};
    assign wb      = {{IDX_W{1'b0}}, i_type_b};
    assign addr_in = wa[IDX_W-1:0];

    always_comb begin
        logic [WIDE_W-1:0] ra_w, rb_w;
        ra_w   = {{IDX_W{1'b0}}, r_ta};
        rb_w   = {{IDX_W{1'b0}}, r_tb};
        addr_a = ra_w[IDX_W-1:0];
        addr_b = rb_w[IDX_W-1:0];
    end

    assign dx17 = 17'(i_ax) - 17'(i_bx);
    assign dy17 = 17'(i_ay) - 17'(i_by);
    assign dz17 = 17'(i_az) - 17'(i_bz);

    assign s_sum = {1'b0, r_ra} + {1'b0, r_rb};
    assign q48   = (|r_q[55:47]) ? CAP : r_q[47:0];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQX:  begin mul_a = {16'd0, r_dx}; mul_b = {16'd0, r_dx}; end
            S_SQY:  begin mul_a = {16'd0, r_dy}; mul_b = {16'd0, r_dy}; end
            S_SQZ:  begin mul_a = {16'd0, r_dz}; mul_b = {16'd0, r_dz}; end
            S_CUT:  begin mul_a = {17'd0, r_cutoff}; mul_b = {17'd0, r_cutoff}; end
            S_SS:   begin mul_a = {19'd0, s_sum}; mul_b = {19'd0, s_sum}; end
            S_DD:   begin mul_a = {16'd0, r_da}; mul_b = {16'd0, r_db}; end
            S_EPS:  begin mul_a = {16'd0, r_vdw_coeff}; mul_b = {16'd0, r_sq_res}; end
            S_MUL: begin
                case (r_sub)
                    3'd0:    begin mul_a = r_t[31:0];          mul_b = q48[31:0]; end
                    3'd1:    begin mul_a = {16'd0, r_t[47:32]}; mul_b = q48[31:0]; end
                    3'd2:    begin mul_a = r_t[31:0];          mul_b = {16'd0, q48[47:32]}; end
                    default: begin mul_a = {16'd0, r_t[47:32]}; mul_b = {16'd0, q48[47:32]}; end
                endcase
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign sq_sh    = {r_sq_rem, r_sq_v[31:30]};
    assign sq_trial = {2'b00, r_sq_res, 2'b01};
    assign div_sh   = {r_rem, r_num[55]};

    assign mul_res = r_acc + {r_prod[31:0], 32'd0};
    assign mul_ovf = (mul_res >= {16'd0, CAP});
    assign mul_cap = mul_ovf ? CAP : mul_res[47:0];

    assign diff = {2'b00, r_t} - {1'b0, r_t6, 1'b0};

    assign sum33   = 33'(r_sum) + 33'(r_term);
    assign sum_ovf = (sum33[32] != sum33[31]);
    assign sum_sat = sum_ovf ? (sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : sum33[31:0];

    assign zero_pair = !r_ok || (r_ra == '0) || (r_rb == '0) || (r_d2 == '0)
                       || (r_d2 >= {4'd0, r_cut2})
                       || (r_cut_mode && ({r_d2, 2'b00} < {10'd0, r_s2}));

    // table storage, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_kind && (wa < wrange)) begin
            r_rad_mem[addr_in] <= i_radius;
            r_dep_mem[addr_in] <= i_well_depth;
        end
        if (r_state == S_RDA) begin
            r_rd_rad <= r_rad_mem[addr_a];
            r_rd_dep <= r_dep_mem[addr_a];
        end else begin
            r_rd_rad <= r_rad_mem[addr_b];
            r_rd_dep <= r_dep_mem[addr_b];
        end
    end

    // multiplier output register
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tab_vld   <= '0;
            r_rd_vld    <= 1'b0;
            r_sum       <= '0;
            r_clip_flag <= 1'b0;
            r_out_valid <= 1'b0;
            r_vdw_coeff <= VDW_COEFF_RST;
            r_cut_mode  <= CUT_MODE_RST;
            r_cutoff    <= CUTOFF_DIST_RST;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_VDW_COEFF:   r_vdw_coeff <= i_cfg_data;
                    CFG_CUT_MODE:    r_cut_mode  <= i_cfg_data[0];
                    CFG_CUTOFF_DIST: r_cutoff    <= i_cfg_data[CUTOFF_W-1:0];
                    default: ;
                endcase
            end

            // drop the output word once taken, unless a new one replaces it
            if (r_out_valid && !i_out_stall && !(r_state == S_ACC && r_last)) begin
                r_out_valid <= 1'b0;
            end

            r_rd_vld <= (r_state == S_RDA) ? r_tab_vld[addr_a] : r_tab_vld[addr_b];

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!i_kind) begin
                            if (wa < wrange) begin
                                r_tab_vld[addr_in] <= 1'b1;
                            end
                        end else begin
                            r_ta    <= i_type_a;
                            r_tb    <= i_type_b;
                            r_ok    <= (wa < wrange) && (wb < wrange);
                            r_last  <= i_last;
                            r_dx    <= dx17[16] ? 16'(-dx17) : dx17[15:0];
                            r_dy    <= dy17[16] ? 16'(-dy17) : dy17[15:0];
                            r_dz    <= dz17[16] ? 16'(-dz17) : dz17[15:0];
                            r_state <= S_RDA;
                        end
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_ra    <= r_rd_vld ? r_rd_rad : '0;
                    r_da    <= r_rd_vld ? r_rd_dep : '0;
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_rb    <= r_rd_vld ? r_rd_rad : '0;
                    r_db    <= r_rd_vld ? r_rd_dep : '0;
                    r_state <= S_SQX;
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: begin
                    r_d2    <= {2'b00, r_prod[31:0]};
                    r_state <= S_SQZ;
                end
                S_SQZ: begin
                    r_d2    <= r_d2 + {2'b00, r_prod[31:0]};
                    r_state <= S_CUT;
                end
                S_CUT: begin
                    r_d2    <= r_d2 + {2'b00, r_prod[31:0]};
                    r_state <= S_SS;
                end
                S_SS: begin
                    r_cut2  <= r_prod[29:0];
                    r_state <= S_DD;
                end
                S_DD: begin
                    r_s2    <= r_prod[25:0];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_sq_v   <= r_prod[31:0];
                    r_sq_rem <= '0;
                    r_sq_res <= '0;
                    r_cnt    <= '0;
                    r_num    <= {r_s2, 30'd0};
                    r_rem    <= '0;
                    r_q      <= '0;
                    r_pclip  <= 1'b0;
                    if (zero_pair) begin
                        r_term  <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // two radicand bits per step
                    r_sq_v <= {r_sq_v[29:0], 2'b00};
                    if (sq_sh >= sq_trial) begin
                        r_sq_rem <= 18'(sq_sh - sq_trial);
                        r_sq_res <= {r_sq_res[14:0], 1'b1};
                    end else begin
                        r_sq_rem <= sq_sh[17:0];
                        r_sq_res <= {r_sq_res[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(SQRT_STEPS - 1)) begin
                        r_state <= S_EPS;
                    end
                end
                S_EPS: r_state <= S_EPW;
                S_EPW: begin
                    r_t     <= {14'd0, r_prod[31:0], 2'b00};
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit per step, divisor is below 2^30 here
                    r_num <= {r_num[54:0], 1'b0};
                    if (div_sh >= {1'b0, r_d2[29:0]}) begin
                        r_rem <= 30'(div_sh - {1'b0, r_d2[29:0]});
                        r_q   <= {r_q[54:0], 1'b1};
                    end else begin
                        r_rem <= div_sh[29:0];
                        r_q   <= {r_q[54:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(DIV_STEPS - 1)) begin
                        r_sub   <= '0;
                        r_midx  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // partial products: low*low, high*low, low*high, high*high
                    case (r_sub)
                        3'd0: ;
                        3'd1: r_acc <= {32'd0, r_prod[63:32]};
                        3'd2, 3'd3: r_acc <= r_acc + r_prod;
                        default: ;
                    endcase
                    if (r_sub == 3'd4) begin
                        r_t <= mul_cap;
                        if (mul_ovf) begin
                            r_pclip <= 1'b1;
                        end
                        if (r_midx == 3'd2) begin
                            r_t6 <= mul_cap;
                        end
                        r_sub <= '0;
                        if (r_midx == 3'(MUL_COUNT - 1)) begin
                            r_state <= S_TERM;
                        end else begin
                            r_midx <= r_midx + 3'd1;
                        end
                    end else begin
                        r_sub <= r_sub + 3'd1;
                    end
                end
                S_TERM: begin
                    r_term  <= r_pclip ? 32'sh7FFF_FFFF : diff[47:16];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_last) begin
                        r_sum       <= sum_sat;
                        r_clip_flag <= r_clip_flag | r_pclip | sum_ovf;
                        r_state     <= S_IDLE;
                    end else if (!r_out_valid || !i_out_stall) begin
                        // emit and clear the running sum
                        r_out_valid  <= 1'b1;
                        r_out_energy <= sum_sat;
                        r_out_sat    <= r_clip_flag | r_pclip | sum_ovf;
                        r_sum        <= '0;
                        r_clip_flag  <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
